### design/base32_stream_encoder_macros.svh
// Assertion macros shared by the base32 stream encoder RTL.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every clock edge outside reset.
`define B32ENC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence holds in the following cycle.
`define B32ENC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`else

`define B32ENC_ASSERT(lbl, clk, rst_n, prop, msg)
`define B32ENC_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

### design/b32enc_pkg.sv
// Types and constants for the base32 stream encoder.
`default_nettype none

package b32enc_pkg;

    localparam int BYTE_W          = 8;
    localparam int GROUP_W         = 5;
    localparam int NUM_ALPHA_WORDS = 4;
    localparam int ALPHA_WORD_W    = 64;
    localparam int CFG_IDX_W       = $clog2(NUM_ALPHA_WORDS);
    localparam int LEFT_BITS_W     = 4;
    localparam int LEFT_CNT_W      = 3;
    localparam int MAX_SYMBOLS     = 3;
    localparam int SYM_CNT_W       = 2;

    typedef logic [GROUP_W-1:0]      t_group;
    typedef logic [ALPHA_WORD_W-1:0] t_alpha_word;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              last_symbol;
    } t_out_item;

endpackage

`default_nettype wire

### design/base32_stream_encoder.sv
// Base32 stream encoder: byte in, programmable-alphabet characters out, unpadded.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one raw byte per
//   transfer, plus an end_of_stream flag that flushes 1..4 leftover bits as a
//   zero-filled final character. The output channel (o_out_valid / i_out_stall
//   / o_out_data) carries one character per transfer; last_symbol marks the
//   final character caused by each input byte. Each byte yields one or two
//   characters, three when a flush adds one. The user must load the alphabet,
//   four 64-bit words of eight characters each, through i_cfg_we / i_cfg_index
//   / i_cfg_data while the block is idle; the block does not enforce this.
// Timing:
//   A transferred byte's group indices are registered in the pending list at
//   its transfer edge; its first character then moves to the output register
//   when that register can load. One character leaves per cycle while the
//   output does not stall; a byte holds the block until all its characters
//   have left, 1.6 on average over a long stream. The next byte is taken in
//   the cycle its predecessor's last character moves to the output register.
// Reset clears the alphabet (all characters read as 0), the bit accumulator
// and both channels. A stall on the output holds the current character;
// the input stalls in reset and until the last pending character can move out.
`default_nettype none
`include "base32_stream_encoder_macros.svh"

module base32_stream_encoder (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input channel
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire b32enc_pkg::t_in_item                 i_in_data,
    // output channel
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      b32enc_pkg::t_out_item                o_out_data,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [b32enc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire b32enc_pkg::t_alpha_word              i_cfg_data
);

    // alphabet registers
    b32enc_pkg::t_alpha_word r_alpha [b32enc_pkg::NUM_ALPHA_WORDS];

    // bit accumulator carried between bytes
    logic [b32enc_pkg::LEFT_BITS_W-1:0] r_bits, n_bits;
    logic [b32enc_pkg::LEFT_CNT_W-1:0]  r_cnt,  n_cnt;

    // pending group indices of the current item, next one in slot 0
    b32enc_pkg::t_group               r_idx [b32enc_pkg::MAX_SYMBOLS];
    b32enc_pkg::t_group               n_idx [b32enc_pkg::MAX_SYMBOLS];
    logic [b32enc_pkg::SYM_CNT_W-1:0] r_left, n_left;

    // output register
    logic                  r_out_valid, n_out_valid;
    b32enc_pkg::t_out_item r_out,       n_out;

    // split of the incoming byte
    logic [b32enc_pkg::LEFT_BITS_W+b32enc_pkg::BYTE_W-1:0] w_acc;
    b32enc_pkg::t_group                 w_g0, w_g1, w_flush;
    logic                               w_two;
    logic [b32enc_pkg::LEFT_BITS_W-1:0] w_rem_bits;
    logic [b32enc_pkg::LEFT_CNT_W-1:0]  w_rem_cnt;
    logic                               w_do_flush;

    logic                               w_out_load;
    logic                               w_emit;
    logic                               w_in_xfer;
    logic [b32enc_pkg::BYTE_W-1:0]      w_sym;

    // handshake
    assign w_out_load  = !r_out_valid || !i_out_stall;
    assign w_emit      = w_out_load && (r_left != '0);
    assign o_in_stall  = !i_rst_n ||
                         !((r_left == '0) || ((r_left == 2'd1) && w_out_load));
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // alphabet lookup for the next pending group
    assign w_sym = r_alpha[r_idx[0][4:3]][{r_idx[0][2:0], 3'b000} +: b32enc_pkg::BYTE_W];

    // cut leftover bits plus the new byte into 5-bit groups, oldest first
    assign w_acc = {r_bits, i_in_data.data_byte};
    always_comb begin
        case (r_cnt)
            3'd0: begin
                w_g0       = w_acc[7:3];
                w_g1       = '0;
                w_two      = 1'b0;
                w_rem_cnt  = 3'd3;
                w_rem_bits = {1'b0, w_acc[2:0]};
                w_flush    = {w_acc[2:0], 2'b00};
            end
            3'd1: begin
                w_g0       = w_acc[8:4];
                w_g1       = '0;
                w_two      = 1'b0;
                w_rem_cnt  = 3'd4;
                w_rem_bits = w_acc[3:0];
                w_flush    = {w_acc[3:0], 1'b0};
            end
            3'd2: begin
                w_g0       = w_acc[9:5];
                w_g1       = w_acc[4:0];
                w_two      = 1'b1;
                w_rem_cnt  = 3'd0;
                w_rem_bits = '0;
                w_flush    = '0;
            end
            3'd3: begin
                w_g0       = w_acc[10:6];
                w_g1       = w_acc[5:1];
                w_two      = 1'b1;
                w_rem_cnt  = 3'd1;
                w_rem_bits = {3'b000, w_acc[0]};
                w_flush    = {w_acc[0], 4'b0000};
            end
            default: begin
                // four leftover bits; larger counts behave the same
                w_g0       = w_acc[11:7];
                w_g1       = w_acc[6:2];
                w_two      = 1'b1;
                w_rem_cnt  = 3'd2;
                w_rem_bits = {2'b00, w_acc[1:0]};
                w_flush    = {w_acc[1:0], 3'b000};
            end
        endcase
        w_do_flush = i_in_data.end_of_stream && (w_rem_cnt != '0);
    end

    // next-state logic
    always_comb begin
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // move the next pending character into the output register
        if (w_out_load) begin
            n_out_valid = w_emit;
        end
        if (w_emit) begin
            n_out.symbol      = w_sym;
            n_out.last_symbol = (r_left == 2'd1);
            n_idx[0]          = r_idx[1];
            n_idx[1]          = r_idx[2];
            n_left            = r_left - 2'd1;
        end

        // load the groups of a newly transferred byte
        if (w_in_xfer) begin
            n_idx[0] = w_g0;
            n_idx[1] = w_two ? w_g1 : w_flush;
            n_idx[2] = w_flush;
            n_left   = {1'b0, w_two} + 2'd1 + {1'b0, w_do_flush};
            if (w_do_flush) begin
                n_bits = '0;
                n_cnt  = '0;
            end else begin
                n_bits = w_rem_bits;
                n_cnt  = w_rem_cnt;
            end
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits      <= '0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < b32enc_pkg::NUM_ALPHA_WORDS; i++) begin
                r_alpha[i] <= '0;
            end
        end else begin
            r_bits      <= n_bits;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_alpha[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_out <= n_out;
    end

    // checks
    `B32ENC_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'd4, "leftover count above four")
    `B32ENC_ASSERT_NEXT(a_xfer_fills, i_clk, i_rst_n, w_in_xfer, r_left != '0, "byte transfer left no pending character")
    `B32ENC_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, w_in_xfer && i_in_data.end_of_stream, r_cnt == '0, "accumulator not cleared after end of stream")
    `B32ENC_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, w_emit, o_out_valid, "emitted character not presented")

endmodule

`default_nettype wire
